/* rtl/core/wpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types, widths and the CORDIC arctangent table for the pose
// accumulator.
// ----------------------------------------------------------------------------
package wpa_pkg;

  // number of CORDIC micro-rotations per pass (8 .. 24)
  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  // CORDIC vector width and angle width
  localparam int CW     = 38;
  localparam int LO_W   = CW / 2;
  localparam int ZW     = 34;
  localparam int PROD_W = LO_W + 1 + 31;
  localparam int ACC_W  = 62;

  // CORDIC gain correction, unsigned Q1.30
  localparam logic [30:0] K_SCALE = 31'd652032874;

  typedef logic signed [CW-1:0] vec_t;
  typedef logic signed [ZW-1:0] ang_t;

  // position types
  localparam logic [1:0] POS_EGO = 2'd0;
  localparam logic [1:0] POS_OFS = 2'd1;
  localparam logic [1:0] POS_ABS = 2'd2;

  // register indexes
  localparam logic REG_EPS_X = 1'b0;
  localparam logic REG_EPS_Y = 1'b1;

  typedef struct packed {
    logic               start_of_list;
    logic [1:0]         pos_type;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [15:0] target_angle;
    logic               angle_relative;
    logic signed [15:0] arc_angle;
    logic               report;
  } item_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] pose_heading;
  } pose_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic mul;
    logic pos;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rot;
    logic step_last;
    logic mul_last;
    logic need_vec;
    logic report;
    logic out_busy;
  } stat_t;

  // arctangent of 2^-i in turns scaled by 2^32
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/wpa_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpa_if
// Valid/ready channels for waypoint items and pose items.
// ----------------------------------------------------------------------------
interface wpa_wp_if;
  logic               valid;
  logic               ready;
  logic               start_of_list;
  logic [1:0]         pos_type;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [15:0] target_angle;
  logic               angle_relative;
  logic signed [15:0] arc_angle;
  logic               report;

  modport source (output valid, start_of_list, pos_type, target_x, target_y,
                  target_angle, angle_relative, arc_angle, report, input ready);
  modport sink (input valid, start_of_list, pos_type, target_x, target_y,
                target_angle, angle_relative, arc_angle, report, output ready);
endinterface

interface wpa_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

/* rtl/core/wpa_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpa_regs
// APB register file holding the turn-in-place epsilon limits.
// ----------------------------------------------------------------------------
module wpa_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [30:0] eps_x,
  output logic [30:0] eps_y
);
  import wpa_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_x <= 31'd1280;
      eps_y <= 31'd1280;
    end else if (wr) begin
      if (paddr[2] == REG_EPS_X) eps_x <= pwdata[30:0];
      else                       eps_y <= pwdata[30:0];
    end
  end

  // read mux
  always_comb begin
    if (paddr[2] == REG_EPS_X) prdata = {1'b0, eps_x};
    else                       prdata = {1'b0, eps_y};
  end
endmodule

/* rtl/core/wpa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpa_ctrl
// Sequencer: load, rotate, scale, place, vector, finish.
// ----------------------------------------------------------------------------
module wpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  wpa_pkg::stat_t st,
  output wpa_pkg::cmd_t  cmd
);
  import wpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROT, S_MUL, S_POS, S_VEC, S_FIN
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // decode commands from state
  always_comb begin
    cmd        = '0;
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.load   = (state == S_LOAD);
    cmd.step   = (state == S_ROT) || (state == S_VEC);
    cmd.mul    = (state == S_MUL);
    cmd.pos    = (state == S_POS);
    cmd.fin    = (state == S_FIN) && !(st.report && st.out_busy);
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_LOAD;
        S_LOAD: state <= st.rot ? S_ROT : S_POS;
        S_ROT:  if (st.step_last) state <= S_MUL;
        S_MUL:  if (st.mul_last) state <= S_POS;
        S_POS:  state <= st.need_vec ? S_VEC : S_FIN;
        S_VEC:  if (st.step_last) state <= S_FIN;
        S_FIN:  if (!(st.report && st.out_busy)) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/wpa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpa_dp
// Pose registers, shared CORDIC unit, gain multiplier and output register.
// ----------------------------------------------------------------------------
module wpa_dp (
  input  logic           clk,
  input  logic           rst,
  input  wpa_pkg::cmd_t  cmd,
  output wpa_pkg::stat_t st,
  input  wpa_pkg::item_t in_item,
  input  logic [30:0]    eps_x,
  input  logic [30:0]    eps_y,
  output logic           out_valid,
  input  logic           out_ready,
  output wpa_pkg::pose_t out_pose
);
  import wpa_pkg::*;

  item_t            it;
  logic [31:0]      cur_x, cur_y;
  logic [15:0]      cur_heading;
  vec_t             cx, cy;
  ang_t             cz;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       mul_cnt;
  logic [ACC_W-1:0] acc;
  logic [31:0]      rot_x, rot_y;
  logic             vec_mode;
  logic             need_vec;

  // load stage
  logic [15:0] hd_eff;
  logic        flip;
  logic [31:0] ang0;
  vec_t        tx_ext, ty_ext;

  // CORDIC step
  logic        cc;
  vec_t        xs, ys;
  ang_t        atan_ext;

  // gain multiply
  vec_t                     mv;
  logic signed [LO_W:0]     chunk;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         prod_ext, acc_sum;

  // place stage
  logic [31:0]        nx, ny;
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic               turn, pos_need;
  vec_t               dx_ext, dy_ext;

  // finish stage
  logic [31:0] zr;
  logic [15:0] atan16, half, head_fin;

  assign hd_eff = it.start_of_list ? 16'd0 : cur_heading;
  assign flip   = hd_eff[15] ^ hd_eff[14];
  assign ang0   = {hd_eff ^ {flip, 15'd0}, 16'd0};
  assign tx_ext = CW'(it.target_x);
  assign ty_ext = CW'(it.target_y);

  // rotate toward z = 0, or drive y to 0 when vectoring
  assign cc       = vec_mode ? !(cy > 0) : !cz[ZW-1];
  assign xs       = cx >>> cnt;
  assign ys       = cy >>> cnt;
  assign atan_ext = ZW'(atan_at(5'(cnt)));

  // one partial product of the gain correction per cycle
  assign mv       = mul_cnt[1] ? cy : cx;
  assign chunk    = mul_cnt[0] ? $signed({mv[CW-1], mv[CW-1:LO_W]})
                               : $signed({1'b0, mv[LO_W-1:0]});
  assign prod     = chunk * $signed({1'b0, K_SCALE});
  assign prod_ext = ACC_W'(prod);
  assign acc_sum  = acc + (prod_ext << LO_W);

  // new position and displacement
  always_comb begin
    case (it.pos_type)
      POS_EGO: begin nx = cur_x + rot_x;      ny = cur_y + rot_y;      end
      POS_OFS: begin nx = cur_x + it.target_x; ny = cur_y + it.target_y; end
      POS_ABS: begin nx = it.target_x;         ny = it.target_y;         end
      default: begin nx = cur_x;               ny = cur_y;               end
    endcase
  end
  assign dx       = $signed({nx[31], nx}) - $signed({cur_x[31], cur_x});
  assign dy       = $signed({ny[31], ny}) - $signed({cur_y[31], cur_y});
  assign adx      = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady      = dy[32] ? 33'(-dy) : 33'(dy);
  assign turn     = (adx < {2'b00, eps_x}) && (ady < {2'b00, eps_y});
  assign pos_need = !turn && it.angle_relative && ((dx != 0) || (dy != 0));
  assign dx_ext   = CW'(dx);
  assign dy_ext   = CW'(dy);

  // rounded arctangent and half arc toward zero
  assign zr       = cz[31:0] + 32'h0000_8000;
  assign atan16   = need_vec ? zr[31:16] : 16'd0;
  assign half     = 16'($signed(it.arc_angle + {15'd0, it.arc_angle[15]}) >>> 1);
  assign head_fin = cur_heading + atan16 + half;

  assign st.rot       = (it.pos_type == POS_EGO);
  assign st.step_last = (cnt == CNT_W'(CORDIC_STEPS - 1));
  assign st.mul_last  = (mul_cnt == 2'd3);
  assign st.need_vec  = pos_need;
  assign st.report    = it.report;
  assign st.out_busy  = out_valid && !out_ready;

  // latch item
  always_ff @(posedge clk) begin
    if (cmd.accept) it <= in_item;
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      cur_heading <= '0;
      need_vec    <= 1'b0;
    end else if (cmd.load) begin
      if (it.start_of_list) begin
        cur_x <= '0;
        cur_y <= '0;
      end
      cur_heading <= hd_eff;
    end else if (cmd.pos) begin
      cur_x    <= nx;
      cur_y    <= ny;
      need_vec <= pos_need;
      if (turn && it.angle_relative) cur_heading <= cur_heading + it.target_angle;
      else                           cur_heading <= it.target_angle;
    end else if (cmd.fin) begin
      cur_heading <= head_fin;
    end
  end

  // CORDIC unit and multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      mul_cnt  <= '0;
      vec_mode <= 1'b0;
    end else if (cmd.load) begin
      cx       <= flip ? -tx_ext : tx_ext;
      cy       <= flip ? -ty_ext : ty_ext;
      cz       <= ZW'($signed(ang0));
      cnt      <= '0;
      mul_cnt  <= '0;
      vec_mode <= 1'b0;
    end else if (cmd.step) begin
      cx  <= cc ? cx - ys : cx + ys;
      cy  <= cc ? cy + xs : cy - xs;
      cz  <= cc ? cz - atan_ext : cz + atan_ext;
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.mul) begin
      mul_cnt <= mul_cnt + 2'd1;
      if (!mul_cnt[0]) acc <= prod_ext + (ACC_W'(1) << 29);
      else if (!mul_cnt[1]) rot_x <= acc_sum[61:30];
      else rot_y <= acc_sum[61:30];
    end else if (cmd.pos) begin
      cx       <= dx[32] ? -dx_ext : dx_ext;
      cy       <= dx[32] ? -dy_ext : dy_ext;
      cz       <= dx[32] ? ZW'(34'h0_8000_0000) : '0;
      cnt      <= '0;
      vec_mode <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin && it.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin && it.report) begin
      out_pose.pose_x       <= cur_x;
      out_pose.pose_y       <= cur_y;
      out_pose.pose_heading <= head_fin;
    end
  end

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.fin && it.report |=> out_valid)
    else $error("reported item did not reach output register");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(CORDIC_STEPS) || CORDIC_STEPS == (1 << CNT_W))
    else $error("step counter out of range");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.mul, cmd.pos, cmd.fin}))
    else $error("datapath commands overlap");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !(cmd.fin && it.report) |=> $stable(out_pose))
    else $error("pending pose overwritten");
endmodule

/* rtl/core/waypoint_pose_accumulator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_pose_accumulator_top
// Planar pose accumulator: applies one waypoint per item, reports the pose of flagged items.
// ----------------------------------------------------------------------------
// Port   Dir  Kind        Item
// wp     in   valid/ready waypoint (type, target, angles, flags)
// pose   out  valid/ready pose x, y, heading
// apb    in   APB r/w     eps_x at 0x0, eps_y at 0x4
//
// An item passes through accept, load, place and finish. An egocentric step
// adds the heading rotation and the gain multiply before place, and an atan2
// pass follows place when the heading follows the move; both passes use the
// single shared CORDIC unit. Reset is synchronous and clears the pose to the
// origin. A stalled pose output holds the finishing item until it is taken.
// ----------------------------------------------------------------------------
module waypoint_pose_accumulator_top (
  input  logic        clk,
  input  logic        rst,
  wpa_wp_if.sink      wp,
  wpa_pose_if.source  pose,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wpa_pkg::*;

  cmd_t        cmd;
  stat_t       st;
  item_t       in_item;
  pose_t       out_pose;
  logic [30:0] eps_x, eps_y;
  logic        out_valid;

  // gather item fields
  assign in_item.start_of_list  = wp.start_of_list;
  assign in_item.pos_type       = wp.pos_type;
  assign in_item.target_x       = wp.target_x;
  assign in_item.target_y       = wp.target_y;
  assign in_item.target_angle   = wp.target_angle;
  assign in_item.angle_relative = wp.angle_relative;
  assign in_item.arc_angle      = wp.arc_angle;
  assign in_item.report         = wp.report;

  assign pose.valid        = out_valid;
  assign pose.pose_x       = out_pose.pose_x;
  assign pose.pose_y       = out_pose.pose_y;
  assign pose.pose_heading = out_pose.pose_heading;

  wpa_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .eps_x, .eps_y
  );

  wpa_ctrl u_ctrl (
    .clk, .rst, .in_valid(wp.valid), .in_ready(wp.ready), .st, .cmd
  );

  wpa_dp u_dp (
    .clk, .rst, .cmd, .st, .in_item, .eps_x, .eps_y,
    .out_valid, .out_ready(pose.ready), .out_pose
  );
endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the planar pose accumulator. A queue of waypoint
// items feeds a clocked driver, and a clocked monitor predicts the pose at
// each accepted item. Reported poses are compared field by field against
// the stored predictions. Both channels idle in random bursts but in the last
// phase, and the epsilon registers are swept over the APB port between phases.
// ----------------------------------------------------------------------------
module tb;
  import wpa_pkg::*;

  localparam int MAX_CYCLES = 1000000;
  localparam int DRAIN      = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wpa_wp_if   wp_ch ();
  wpa_pose_if pose_ch ();

  waypoint_pose_accumulator_top DUT (
    .clk(clk), .rst(rst), .wp(wp_ch), .pose(pose_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  item_t   waypoint_q[$];
  pose_t   pose_expected[$];
  int      errors = 0;
  int      cycles = 0;
  bit      quiet_tail = 1'b0;
  logic    wp_fire = 1'b0;
  int      wp_gap = 0;
  int      pose_stall = 0;

  // predicted pose and epsilon registers
  logic [31:0] model_x = '0, model_y = '0;
  logic [15:0] model_heading = '0;
  logic [30:0] model_eps_x = 31'd1280, model_eps_y = 31'd1280;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic longint gain_fix(longint v);
    return (v * 64'sd652032874 + (64'sd1 << 29)) >>> 30;
  endfunction

  // rotate (x, y) by the heading angle given in turns scaled by 2^32
  function automatic void rotate_step(inout longint x, inout longint y,
                                      input logic [31:0] a);
    longint z, nx, ny;
    if ((a - 32'h40000000) < 32'h80000000) begin
      x = -x;
      y = -y;
      a = a - 32'h80000000;
    end
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z  = z - longint'(ATAN_TURNS[i]);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z  = z + longint'(ATAN_TURNS[i]);
      end
      x = nx;
      y = ny;
    end
    x = gain_fix(x);
    y = gain_fix(y);
  endfunction

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    logic [31:0] z;
    longint nx, ny;
    z = '0;
    if (dx == 0 && dy == 0) return 16'd0;
    if (dx < 0) begin
      dx = -dx;
      dy = -dy;
      z  = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (dy > 0) begin
        nx = dx + (dy >>> i);
        ny = dy - (dx >>> i);
        z  = z + ATAN_TURNS[i];
      end else begin
        nx = dx - (dy >>> i);
        ny = dy + (dx >>> i);
        z  = z - ATAN_TURNS[i];
      end
      dx = nx;
      dy = ny;
    end
    z = z + 32'h8000;
    return z[31:16];
  endfunction

  // advance the predicted pose by one waypoint; queue the pose if reported
  task automatic apply_waypoint(input item_t w);
    logic [31:0] nx, ny;
    logic signed [15:0] half;
    longint rx, ry, dx, dy, adx, ady;
    if (w.start_of_list) begin
      model_x = '0;
      model_y = '0;
      model_heading = '0;
    end
    nx = model_x;
    ny = model_y;
    case (w.pos_type)
      POS_EGO: begin
        rx = longint'(w.target_x);
        ry = longint'(w.target_y);
        rotate_step(rx, ry, {model_heading, 16'h0000});
        nx = model_x + rx[31:0];
        ny = model_y + ry[31:0];
      end
      POS_OFS: begin
        nx = model_x + w.target_x;
        ny = model_y + w.target_y;
      end
      POS_ABS: begin
        nx = w.target_x;
        ny = w.target_y;
      end
      default: ;
    endcase
    dx = longint'($signed(nx)) - longint'($signed(model_x));
    dy = longint'($signed(ny)) - longint'($signed(model_y));
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    model_x = nx;
    model_y = ny;
    if (adx < longint'(model_eps_x) && ady < longint'(model_eps_y)) begin
      model_heading = w.angle_relative ? model_heading + w.target_angle
                                       : w.target_angle;
    end else begin
      model_heading = w.target_angle;
      if (w.angle_relative) model_heading = model_heading + bearing_of(dx, dy);
    end
    half = w.arc_angle / 16'sd2;
    model_heading = model_heading + half;
    if (w.report) pose_expected.push_back('{model_x, model_y, model_heading});
  endtask

  // waypoint driver: hold until taken, idle in random bursts
  always @(negedge clk) begin
    if (rst) begin
      wp_ch.valid          <= 1'b0;
      wp_ch.start_of_list  <= 1'b0;
      wp_ch.pos_type       <= POS_EGO;
      wp_ch.target_x       <= '0;
      wp_ch.target_y       <= '0;
      wp_ch.target_angle   <= '0;
      wp_ch.angle_relative <= 1'b0;
      wp_ch.arc_angle      <= '0;
      wp_ch.report         <= 1'b0;
    end else if (wp_ch.valid && !wp_fire) begin
      wp_ch.valid <= 1'b1;
    end else if (wp_gap > 0) begin
      wp_gap <= wp_gap - 1;
      wp_ch.valid <= 1'b0;
    end else if (waypoint_q.size() != 0) begin
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        wp_gap <= $urandom_range(1, 18) - 1;
        wp_ch.valid <= 1'b0;
      end else begin
        item_t w;
        w = waypoint_q.pop_front();
        wp_ch.valid          <= 1'b1;
        wp_ch.start_of_list  <= w.start_of_list;
        wp_ch.pos_type       <= w.pos_type;
        wp_ch.target_x       <= w.target_x;
        wp_ch.target_y       <= w.target_y;
        wp_ch.target_angle   <= w.target_angle;
        wp_ch.angle_relative <= w.angle_relative;
        wp_ch.arc_angle      <= w.arc_angle;
        wp_ch.report         <= w.report;
      end
    end else begin
      wp_ch.valid <= 1'b0;
    end
  end

  // pose sink: stall in random bursts
  always @(negedge clk) begin
    if (rst || quiet_tail) begin
      pose_ch.ready <= !rst;
      pose_stall <= 0;
    end else if (pose_stall > 0) begin
      pose_stall <= pose_stall - 1;
      pose_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      pose_stall <= $urandom_range(1, 18) - 1;
      pose_ch.ready <= 1'b0;
    end else begin
      pose_ch.ready <= 1'b1;
    end
  end

  // monitor: predict at each accepted waypoint, check each taken pose
  always @(posedge clk) begin
    pose_t got, exp_pose;
    wp_fire <= wp_ch.valid && wp_ch.ready && !rst;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_EPS_X) model_eps_x = pwdata[30:0];
        else model_eps_y = pwdata[30:0];
      end
      if (wp_ch.valid && wp_ch.ready)
        apply_waypoint('{wp_ch.start_of_list, wp_ch.pos_type, wp_ch.target_x,
                         wp_ch.target_y, wp_ch.target_angle, wp_ch.angle_relative,
                         wp_ch.arc_angle, wp_ch.report});
      if (pose_ch.valid && pose_ch.ready) begin
        got = '{pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading};
        if (pose_expected.size() == 0) begin
          $error("pose with no prediction: x=%0d y=%0d heading=%0d",
                 got.pose_x, got.pose_y, got.pose_heading);
          errors++;
        end else begin
          exp_pose = pose_expected.pop_front();
          if (got.pose_x !== exp_pose.pose_x) begin
            $error("pose_x expected %0d got %0d", exp_pose.pose_x, got.pose_x);
            errors++;
          end
          if (got.pose_y !== exp_pose.pose_y) begin
            $error("pose_y expected %0d got %0d", exp_pose.pose_y, got.pose_y);
            errors++;
          end
          if (got.pose_heading !== exp_pose.pose_heading) begin
            $error("pose_heading expected %0d got %0d",
                   exp_pose.pose_heading, got.pose_heading);
            errors++;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic item_t waypoint(logic sol, logic [1:0] pt, logic [31:0] x,
                                     logic [31:0] y, logic [15:0] ang, logic rel,
                                     logic [15:0] arc, logic rep);
    item_t w;
    w = '{sol, pt, x, y, ang, rel, arc, rep};
    return w;
  endfunction

  // mostly bounded steps (half small, some up to a million), some full-range noise
  function automatic item_t random_waypoint();
    item_t w;
    logic [31:0] x, y;
    int sel;
    sel = $urandom_range(0, 9);
    x = $urandom();
    y = $urandom();
    if (sel < 5) begin
      x = 32'($signed($urandom_range(0, 8192)) - 4096);
      y = 32'($signed($urandom_range(0, 8192)) - 4096);
    end else if (sel < 7) begin
      x = 32'($signed($urandom_range(0, 2000000)) - 1000000);
      y = 32'($signed($urandom_range(0, 2000000)) - 1000000);
    end
    w = waypoint($urandom_range(0, 19) == 0,
                 $urandom_range(0, 19) == 0 ? 2'd3 : 2'($urandom_range(0, 2)),
                 x, y, 16'($urandom()), 1'($urandom()), 16'($urandom()),
                 $urandom_range(0, 2) != 0);
    return w;
  endfunction

  task automatic apb_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (waypoint_q.size() != 0 || wp_ch.valid || pose_expected.size() != 0)
      @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic run_random(input int n);
    repeat (n) waypoint_q.push_back(random_waypoint());
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every position type, corner cases
    waypoint_q.push_back(waypoint(1, POS_OFS, 32'd0, 32'd0, 16'd0, 0, 16'd0, 1));
    waypoint_q.push_back(waypoint(0, POS_ABS, 32'h7FFFFFFF, 32'h80000000,
                                  16'h7FFF, 1, 16'h7FFF, 1));
    waypoint_q.push_back(waypoint(0, POS_OFS, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  16'h8000, 0, 16'h8000, 1));
    waypoint_q.push_back(waypoint(0, POS_EGO, 32'h80000000, 32'h80000000,
                                  16'h4000, 1, 16'hFFFF, 1));
    waypoint_q.push_back(waypoint(0, POS_EGO, 32'h7FFFFFFF, 32'h80000000,
                                  16'hC000, 1, 16'h0001, 1));
    waypoint_q.push_back(waypoint(0, 2'd3, 32'hFFFFFFFF, 32'h12345678,
                                  16'h1234, 1, 16'h0003, 1));
    waypoint_q.push_back(waypoint(0, 2'd3, 32'd5, 32'd7, 16'hABCD, 0, 16'hFFFD, 1));
    waypoint_q.push_back(waypoint(1, POS_EGO, 32'd1279, 32'hFFFFFB01,
                                  16'h2000, 1, 16'd0, 1));
    waypoint_q.push_back(waypoint(0, POS_EGO, 32'd1280, 32'd0, 16'h0100, 1, 16'd0, 1));
    waypoint_q.push_back(waypoint(0, POS_OFS, 32'd0, 32'hFFFFFB00, 16'h0, 1, 16'd0, 1));
    waypoint_q.push_back(waypoint(0, POS_OFS, 32'hFFFFFB01, 32'd1279, 16'h10, 1,
                                  16'd0, 0));
    waypoint_q.push_back(waypoint(0, POS_EGO, 32'd1000000, 32'd0, 16'h0, 1, 16'h0, 1));
    waypoint_q.push_back(waypoint(0, POS_EGO, 32'd0, 32'hFFF00000, 16'h8000, 0,
                                  16'h0, 1));
    waypoint_q.push_back(waypoint(0, POS_ABS, 32'd0, 32'd0, 16'h7000, 1, 16'h8001, 1));
    waypoint_q.push_back(waypoint(1, POS_ABS, 32'hFFFF0000, 32'd65536, 16'h0, 1,
                                  16'd0, 1));
    wait_idle();

    // zero epsilons: a zero move still takes the move branch
    apb_write(REG_EPS_X, 32'd0);
    apb_write(REG_EPS_Y, 32'd0);
    waypoint_q.push_back(waypoint(1, POS_OFS, 32'd0, 32'd0, 16'h1111, 1, 16'd0, 1));
    waypoint_q.push_back(waypoint(0, 2'd3, 32'd9, 32'd9, 16'h2222, 1, 16'h0002, 1));
    run_random(300);

    // widest epsilons: any move under 2^31 - 1 on both axes turns in place
    apb_write(REG_EPS_X, 32'h7FFFFFFF);
    apb_write(REG_EPS_Y, 32'hFFFFFFFF);
    run_random(250);

    // mixed settings
    apb_write(REG_EPS_X, 32'h7FFFFFFF);
    apb_write(REG_EPS_Y, 32'd0);
    run_random(200);
    apb_write(REG_EPS_X, 32'($urandom_range(0, 8192)));
    apb_write(REG_EPS_Y, 32'($urandom_range(0, 8192)));
    run_random(300);
    apb_write(REG_EPS_X, $urandom());
    apb_write(REG_EPS_Y, $urandom());
    run_random(150);

    // back to the default epsilon, no idling on either side
    apb_write(REG_EPS_X, 32'd1280);
    apb_write(REG_EPS_Y, 32'd1280);
    quiet_tail = 1'b1;
    run_random(430);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
